FILE: hw/rtl/byte_stuffing_frame_encoder_assert.svh
// Assertion macros shared by the encoder RTL.
`ifndef BYTE_STUFFING_FRAME_ENCODER_ASSERT_SVH
`define BYTE_STUFFING_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BSFE_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BSFE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bsfe_pkg.sv
`timescale 1ns / 1ps
package bsfe_pkg;

    localparam int FifoDepth = 4;

    // config register indexes
    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_ESCAPE = 2'd1;
    localparam logic [1:0] REG_TAIL   = 2'd2;

    // emission phases of one command, in link order
    localparam logic [2:0] PH_H1 = 3'd0;
    localparam logic [2:0] PH_H2 = 3'd1;
    localparam logic [2:0] PH_EB = 3'd2;
    localparam logic [2:0] PH_B  = 3'd3;
    localparam logic [2:0] PH_ES = 3'd4;
    localparam logic [2:0] PH_S  = 3'd5;
    localparam logic [2:0] PH_T1 = 3'd6;
    localparam logic [2:0] PH_T2 = 3'd7;
    localparam int PhCount = 8;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] escape;
        logic [7:0] tail;
    } marks_t;

    // one classified input beat
    typedef struct packed {
        logic [7:0] data;
        logic       data_esc;
        logic       first;
        logic       last;
        logic [7:0] sum;
        logic       sum_esc;
    } cmd_t;

    typedef struct packed {
        logic       done;
        logic [2:0] ph;
    } step_t;

    function automatic logic is_mark(logic [7:0] b, marks_t m);
        return (b == m.header) || (b == m.escape) || (b == m.tail);
    endfunction

    function automatic logic phase_en(cmd_t c, logic [2:0] p);
        logic en;
        case (p)
            PH_H1, PH_H2:        en = c.first;
            PH_EB:               en = c.data_esc;
            PH_B:                en = 1'b1;
            PH_ES:               en = c.last & c.sum_esc;
            PH_S, PH_T1, PH_T2:  en = c.last;
            default:             en = 1'b0;
        endcase
        return en;
    endfunction

    // next enabled phase after p; done when none is left
    function automatic step_t next_phase(cmd_t c, logic [2:0] p);
        step_t s;
        s.done = 1'b1;
        s.ph   = p;
        for (int i = PhCount - 1; i >= 1; i--) begin
            if ((3'(i) > p) && phase_en(c, 3'(i)))
            begin
                s.done = 1'b0;
                s.ph   = 3'(i);
            end
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/bsfe_front.sv
`timescale 1ns / 1ps
module bsfe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  bsfe_pkg::marks_t marks,
    input  logic           in_valid,
    input  logic [7:0]     in_data,
    input  logic           in_first,
    input  logic           in_last,
    input  logic           q_full,
    output logic           in_ready,
    output logic           push,
    output bsfe_pkg::cmd_t cmd
);
    import bsfe_pkg::*;

    logic [7:0] sum_reg, sum_next;
    logic [7:0] sum_new;

    assign in_ready = ~q_full;
    assign push     = in_valid & in_ready;

    // a first byte restarts the checksum
    assign sum_new = (in_first ? 8'd0 : sum_reg) + in_data;

    always_comb
    begin
        cmd.data     = in_data;
        cmd.data_esc = is_mark(in_data, marks);
        cmd.first    = in_first;
        cmd.last     = in_last;
        cmd.sum      = sum_new;
        cmd.sum_esc  = is_mark(sum_new, marks);
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (push)
        begin
            sum_next = in_last ? 8'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'd0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

FILE: hw/rtl/bsfe_fifo.sv
`timescale 1ns / 1ps
`include "byte_stuffing_frame_encoder_assert.svh"
module bsfe_fifo #(
    parameter int DEPTH = bsfe_pkg::FifoDepth
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsfe_pkg::cmd_t wr_cmd,
    input  logic           pop,
    output bsfe_pkg::cmd_t rd_cmd,
    output logic           full,
    output logic           empty
);
    import bsfe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = mem[rd_ptr_reg];

    function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BSFE_CHECK(a_no_overflow, push, !full, "fifo push while full")
    `BSFE_CHECK(a_no_underflow, pop, !empty, "fifo pop while empty")

endmodule

FILE: hw/rtl/bsfe_back.sv
`timescale 1ns / 1ps
`include "byte_stuffing_frame_encoder_assert.svh"
module bsfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bsfe_pkg::marks_t marks,
    input  bsfe_pkg::cmd_t   head,
    input  logic             q_empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_run_last,
    output logic             out_frame_end
);
    import bsfe_pkg::*;

    cmd_t       cur_reg, cur_next;
    logic       have_reg, have_next;
    logic [2:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_last_reg, run_last_next;
    logic       frame_end_reg, frame_end_next;

    cmd_t       src;
    logic [2:0] start_ph;
    logic [2:0] cur_ph;
    step_t      step;
    logic       can_load;
    logic       fire;
    logic [7:0] ph_byte;

    assign src      = have_reg ? cur_reg : head;
    assign start_ph = head.first ? PH_H1 : (head.data_esc ? PH_EB : PH_B);
    assign cur_ph   = have_reg ? phase_reg : start_ph;
    assign step     = next_phase(src, cur_ph);
    assign can_load = ~valid_reg | out_ready;
    assign fire     = can_load & (have_reg | ~q_empty);
    // head leaves the queue as soon as its first byte goes out
    assign pop      = fire & ~have_reg;

    always_comb
    begin
        case (cur_ph)
            PH_H1, PH_H2: ph_byte = marks.header;
            PH_EB, PH_ES: ph_byte = marks.escape;
            PH_B:         ph_byte = src.data;
            PH_S:         ph_byte = src.sum;
            PH_T1, PH_T2: ph_byte = marks.tail;
            default:      ph_byte = src.data;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        have_next      = have_reg;
        phase_next     = phase_reg;
        valid_next     = valid_reg & ~out_ready;
        byte_next      = byte_reg;
        run_last_next  = run_last_reg;
        frame_end_next = frame_end_reg;
        if (fire)
        begin
            valid_next     = 1'b1;
            byte_next      = ph_byte;
            run_last_next  = step.done;
            frame_end_next = (cur_ph == PH_T2);
            have_next      = ~step.done;
            cur_next       = src;
            phase_next     = step.ph;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        byte_reg      <= byte_next;
        run_last_reg  <= run_last_next;
        frame_end_reg <= frame_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            phase_reg <= PH_B;
            valid_reg <= 1'b0;
        end
        else
        begin
            have_reg  <= have_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_run_last  = run_last_reg;
    assign out_frame_end = frame_end_reg;

    `BSFE_CHECK(a_end_is_run_last, valid_reg && frame_end_reg, run_last_reg,
        "frame end without run end")
    `BSFE_CHECK(a_held_not_h1, have_reg, phase_reg != PH_H1,
        "held command parked on first header")
    `BSFE_CHECK_NEXT(a_pop_loads_valid, pop, valid_reg,
        "popped command emitted no beat")

endmodule

FILE: hw/rtl/byte_stuffing_frame_encoder.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] data_byte, tuser first_byte, tlast last_byte
// m_axis    out  tdata[7:0] out_byte, tuser frame_end, tlast run_last
// cfg       in   cfg_index selects header/escape/tail mark, cfg_data value
//
// The back end sends one link byte per cycle unless stalled; a middle byte
// gives 1 or 2 bytes, a first up to 4, a last up to 6, a one-byte frame up to 8.
// The front end takes one beat per cycle while the command queue has room.
// The output register lets a new beat load in the same cycle the old one leaves.
// Reset (rst_n low, asynchronous) clears checksum, queue and output; marks reload.
module byte_stuffing_frame_encoder #(
    parameter int FIFO_DEPTH = bsfe_pkg::FifoDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // first_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // frame_end
    output logic       m_tlast,   // run_last
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import bsfe_pkg::*;

    marks_t marks_reg, marks_next;
    cmd_t   push_cmd;
    cmd_t   head_cmd;
    logic   push, pop, q_full, q_empty;

    always_comb
    begin
        marks_next = marks_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HEADER: marks_next.header = cfg_data;
                REG_ESCAPE: marks_next.escape = cfg_data;
                REG_TAIL:   marks_next.tail   = cfg_data;
                default:    marks_next = marks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg.header <= 8'd170;
            marks_reg.escape <= 8'd165;
            marks_reg.tail   <= 8'd85;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

    bsfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .marks    (marks_reg),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .in_first (s_tuser),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .cmd      (push_cmd)
    );

    bsfe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    bsfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .marks         (marks_reg),
        .head          (head_cmd),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_run_last  (m_tlast),
        .out_frame_end (m_tuser)
    );

endmodule

FILE: tb/sv/tb_byte_stuffing_frame_encoder.sv
`timescale 1ns / 1ps
module tb_byte_stuffing_frame_encoder;
    import bsfe_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, write must be dropped
    localparam int HoldCycles = 150;
    localparam int PhaseBytes = 40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } link_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'h00;

    marks_t     link_marks;
    logic [7:0] frame_sum;
    link_beat_t link_q[$];
    link_beat_t pend[8];
    int         pend_n;
    link_beat_t want;
    int         err_count = 0;

    bit   src_idle_on = 1'b0;
    logic sink_idle_on = 1'b0;
    logic sink_hold = 1'b0;
    int   sink_gap = 0;
    event hold_go;

    byte_stuffing_frame_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, exp_val, $time);
        err_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- encoder prediction ----------------
    function automatic void pend_add(logic [7:0] b, logic fe);
        pend[pend_n] = '{out_byte: b, run_last: 1'b0, frame_end: fe};
        pend_n++;
    endfunction

    function automatic void pend_stuffed(logic [7:0] b);
        if (b == link_marks.header || b == link_marks.escape || b == link_marks.tail)
            pend_add(link_marks.escape, 1'b0);
        pend_add(b, 1'b0);
    endfunction

    function automatic void predict_link_bytes(logic [7:0] b, logic f, logic l);
        link_beat_t beat;
        pend_n = 0;
        if (f)
        begin
            frame_sum = 8'h00;
            pend_add(link_marks.header, 1'b0);
            pend_add(link_marks.header, 1'b0);
        end
        pend_stuffed(b);
        frame_sum = frame_sum + b;
        if (l)
        begin
            pend_stuffed(frame_sum);
            pend_add(link_marks.tail, 1'b0);
            pend_add(link_marks.tail, 1'b1);
            frame_sum = 8'h00;
        end
        for (int i = 0; i < pend_n; i++)
        begin
            beat = pend[i];
            beat.run_last = (i == pend_n - 1);
            link_q.push_back(beat);
        end
    endfunction

    // ---------------- link side ----------------
    always @(posedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if (sink_idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= pick_gap() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            sink_hold <= 1'b1;
            repeat (HoldCycles) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (link_q.size() == 0)
                report_mismatch("link beat with nothing pending", int'(m_tdata), 0);
            else
            begin
                want = link_q.pop_front();
                if (m_tdata !== want.out_byte)
                    report_mismatch("out_byte", int'(m_tdata), int'(want.out_byte));
                if (m_tlast !== want.run_last)
                    report_mismatch("run_last", int'(m_tlast), int'(want.run_last));
                if (m_tuser !== want.frame_end)
                    report_mismatch("frame_end", int'(m_tuser), int'(want.frame_end));
            end
        end
    end

    // ---------------- byte side ----------------
    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= f;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_link_bytes(b, f, l);
        gap = 0;
        if (src_idle_on && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (link_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_mark(input logic [1:0] idx, input logic [7:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HEADER: link_marks.header = v;
            REG_ESCAPE: link_marks.escape = v;
            REG_TAIL:   link_marks.tail   = v;
            default:    ;
        endcase
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return link_marks.header;
            1:       return link_marks.escape;
            2:       return link_marks.tail;
            3:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic send_random_frame(input bit broken, output int n);
        logic f;
        logic l;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 10);
        for (int i = 0; i < n; i++)
        begin
            f = (i == 0);
            l = (i == n - 1);
            if (broken)
            begin
                f = 1'($urandom_range(0, 1));
                l = 1'($urandom_range(0, 1));
            end
            send_byte(pick_byte(), f, l);
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_default_marks();
        src_idle_on = 1'b1;
        sink_idle_on <= 1'b1;
        // one-byte frame whose byte and checksum both hit the header mark
        send_byte(8'hAA, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h07, 1'b0, 1'b1);
        // checksum lands on the tail mark
        send_byte(8'h50, 1'b1, 1'b0);
        send_byte(8'h05, 1'b0, 1'b1);
        // no opening byte: sum runs from the previous frame end
        send_byte(8'h10, 1'b0, 1'b0);
        send_byte(8'h20, 1'b0, 1'b0);
        send_byte(8'h30, 1'b0, 1'b1);
        // abandoned frame, next first byte restarts the sum
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'h22, 1'b0, 1'b0);
        send_byte(8'h33, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_mark_registers();
        write_mark(REG_HEADER, 8'h00);
        write_mark(REG_ESCAPE, 8'hFF);
        write_mark(REG_TAIL, 8'h00);
        write_mark(REG_SPARE, 8'h12);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        write_mark(REG_HEADER, 8'hFF);
        write_mark(REG_ESCAPE, 8'h00);
        write_mark(REG_TAIL, 8'hFF);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h12, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        int k;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_mark(REG_HEADER, 8'($urandom()));
                    write_mark(REG_ESCAPE, 8'($urandom()));
                    write_mark(REG_TAIL, 8'($urandom()));
                end
                1:
                begin
                    // header and escape share a value
                    write_mark(REG_HEADER, 8'($urandom()));
                    write_mark(REG_ESCAPE, link_marks.header);
                    write_mark(REG_TAIL, 8'($urandom()));
                end
                2:
                begin
                    write_mark(REG_HEADER, 8'h00);
                    write_mark(REG_ESCAPE, 8'hFF);
                    write_mark(REG_TAIL, 8'h80);
                end
                default:
                begin
                    write_mark(REG_HEADER, 8'hAA);
                    write_mark(REG_ESCAPE, 8'hA5);
                    write_mark(REG_TAIL, 8'h55);
                end
            endcase
            src_idle_on = (phase != 2);
            sink_idle_on <= (phase != 3);
            sent = 0;
            while (sent < PhaseBytes)
            begin
                send_random_frame($urandom_range(0, 9) < 2, k);
                sent += k;
            end
            wait_idle();
        end
    endtask

    task automatic test_link_backpressure();
        int k;
        src_idle_on = 1'b0;
        -> hold_go;
        for (int i = 0; i < 4; i++)
            send_random_frame(1'b0, k);
        src_idle_on = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        link_marks = '{header: 8'hAA, escape: 8'hA5, tail: 8'h55};
        frame_sum  = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_marks();
        test_mark_registers();
        test_random_frames();
        test_link_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (link_q.size() != 0)
            report_mismatch("link beats never seen", 0, link_q.size());
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bsfe_pkg.sv
hw/rtl/bsfe_front.sv
hw/rtl/bsfe_fifo.sv
hw/rtl/bsfe_back.sv
hw/rtl/byte_stuffing_frame_encoder.sv
tb/sv/tb_byte_stuffing_frame_encoder.sv
